// ===== hdl/rssd_pkg.sv =====
package rssd_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ENTRIES   = 256;
	localparam int ENTRY_W   = 8;
	localparam int CNT_W     = 32;
	localparam int SUM_W     = 48;
	localparam int MEAN_W    = 48;
	localparam int SQ_W      = 64;
	localparam int LIMB_W    = 32;
	localparam int LIMBS     = 7;
	localparam int LIMB_IW   = 3;
	localparam int BIG_W     = LIMB_W * LIMBS;
	localparam int DIV_W     = 64;
	localparam int DIV_CW    = 6;

	// Interval test scaled to integers: 1.96^2 = 2401/625, so
	// 2401*V*2^(32+F) < 2500*n*E^2*m^2.
	localparam logic [11:0] INTERVAL_Z2 = 12'd2401;
	localparam logic [11:0] RHS_SCALE   = 12'd2500;
	localparam int          LHS_SHIFT   = LIMB_W + FRAC_BITS;
	localparam logic [SQ_W-1:0] VAR_EMPTY = SQ_W'(1000) << FRAC_BITS;

	localparam logic [1:0] MODE_SAMPLE = 2'd0;
	localparam logic [1:0] MODE_LOCAL  = 2'd1;
	localparam logic [1:0] MODE_GLOBAL = 2'd2;

	localparam logic [2:0] CFG_RATE_MODE   = 3'd0;
	localparam logic [2:0] CFG_UPDATE_EN   = 3'd1;
	localparam logic [2:0] CFG_COUNT_LIMIT = 3'd2;
	localparam logic [2:0] CFG_TIME_LIMIT  = 3'd3;
	localparam logic [2:0] CFG_ERROR_LIMIT = 3'd4;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  entry;
		logic [31:0] exec_time_ns;
		logic [31:0] work_units;
		logic        keep_sched;
		logic        barrier_key;
	} in_item_t;

	typedef struct packed {
		logic [47:0] mean_value;
		logic [63:0] variance_value;
		logic        steady_met;
		logic        schedule_local;
		logic        schedule_global;
		logic [31:0] sample_count;
	} out_item_t;

	typedef struct packed {
		logic        rate_mode;
		logic        update_enable;
		logic [31:0] count_limit;
		logic [47:0] time_limit_ns;
		logic [31:0] error_limit_q16;
	} cfg_t;

	typedef struct packed {
		logic              local_mark;
		logic              global_mark;
		logic [CNT_W-1:0]  count;
		logic [CNT_W-1:0]  skip_count;
		logic [SUM_W-1:0]  unit_sum;
		logic [SUM_W-1:0]  skip_unit_sum;
		logic [SUM_W-1:0]  time_sum;
		logic [MEAN_W-1:0] mean;
		logic [SQ_W-1:0]   sqdev;
	} row_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_READ, ST_LATCH, ST_DECIDE, ST_RDIV_GO, ST_RDIV, ST_DELTA,
		ST_DDIV_GO, ST_DDIV, ST_MEAN, ST_RESID, ST_PMUL_GO, ST_PMUL, ST_WRITE,
		ST_VAR, ST_VDIV, ST_LHS_GO, ST_LHS, ST_RHS_GO, ST_RHS, ST_FINISH
	} ctl_state_t;

	typedef enum logic [4:0] {
		DP_NONE, DP_CAPTURE, DP_LATCH_ROW, DP_FOLD_PREP, DP_OTHER_UPD, DP_X_TAKE,
		DP_DELTA, DP_DIV_START, DP_MEAN_UPD, DP_RESID, DP_MUL_START, DP_SQ_UPD,
		DP_WRITE, DP_VAR_CONST, DP_VAR_TAKE, DP_LHS_TAKE, DP_FINISH
	} dp_op_t;

	typedef enum logic [1:0] {
		DS_RATE, DS_DELTA, DS_VAR
	} div_src_t;

	typedef enum logic [2:0] {
		MS_SQDEV, MS_LHS, MS_RHS_N, MS_CHAIN_E, MS_CHAIN_M
	} mul_src_t;

	typedef struct packed {
		dp_op_t   op;
		div_src_t div_src;
		mul_src_t mul_src;
	} dp_cmd_t;

	typedef struct packed {
		logic fold;
		logic rate;
		logic var_const;
		logic div_busy;
		logic mul_busy;
	} dp_status_t;

	function automatic logic [SUM_W-1:0] sat_add48(logic [SUM_W-1:0] a, logic [31:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W + 1)'(b);
		return s[SUM_W] ? '1 : s[SUM_W-1:0];
	endfunction

endpackage

// ===== hdl/rssd_ctrl.sv =====
module rssd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rssd_pkg::dp_status_t status,
	output rssd_pkg::dp_cmd_t   cmd
);
	import rssd_pkg::*;

	localparam logic [2:0] RHS_LAST = 3'd4;

	ctl_state_t state_q, state_d;
	logic [2:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		cmd.op      = DP_NONE;
		cmd.div_src = DS_VAR;
		cmd.mul_src = MS_SQDEV;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.op  = DP_CAPTURE;
					state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_LATCH;
			ST_LATCH: begin
				cmd.op  = DP_LATCH_ROW;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (status.fold) begin
					cmd.op  = DP_FOLD_PREP;
					state_d = status.rate ? ST_RDIV_GO : ST_DELTA;
				end else begin
					cmd.op  = DP_OTHER_UPD;
					state_d = ST_WRITE;
				end
			end
			ST_RDIV_GO: begin
				cmd.op      = DP_DIV_START;
				cmd.div_src = DS_RATE;
				state_d     = ST_RDIV;
			end
			ST_RDIV: begin
				if (!status.div_busy) begin
					cmd.op  = DP_X_TAKE;
					state_d = ST_DELTA;
				end
			end
			ST_DELTA: begin
				cmd.op  = DP_DELTA;
				state_d = ST_DDIV_GO;
			end
			ST_DDIV_GO: begin
				cmd.op      = DP_DIV_START;
				cmd.div_src = DS_DELTA;
				state_d     = ST_DDIV;
			end
			ST_DDIV: begin
				if (!status.div_busy) begin
					cmd.op  = DP_MEAN_UPD;
					state_d = ST_RESID;
				end
			end
			ST_RESID: begin
				cmd.op  = DP_RESID;
				state_d = ST_PMUL_GO;
			end
			ST_PMUL_GO: begin
				cmd.op      = DP_MUL_START;
				cmd.mul_src = MS_SQDEV;
				state_d     = ST_PMUL;
			end
			ST_PMUL: begin
				if (!status.mul_busy) begin
					cmd.op  = DP_SQ_UPD;
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				cmd.op  = DP_WRITE;
				state_d = ST_VAR;
			end
			ST_VAR: begin
				if (status.var_const) begin
					cmd.op  = DP_VAR_CONST;
					state_d = ST_LHS_GO;
				end else begin
					cmd.op      = DP_DIV_START;
					cmd.div_src = DS_VAR;
					state_d     = ST_VDIV;
				end
			end
			ST_VDIV: begin
				if (!status.div_busy) begin
					cmd.op  = DP_VAR_TAKE;
					state_d = ST_LHS_GO;
				end
			end
			ST_LHS_GO: begin
				cmd.op      = DP_MUL_START;
				cmd.mul_src = MS_LHS;
				state_d     = ST_LHS;
			end
			ST_LHS: begin
				if (!status.mul_busy) begin
					cmd.op  = DP_LHS_TAKE;
					step_d  = '0;
					state_d = ST_RHS_GO;
				end
			end
			ST_RHS_GO: begin
				cmd.op = DP_MUL_START;
				case (step_q)
					3'd0: cmd.mul_src = MS_RHS_N;
					3'd1, 3'd2: cmd.mul_src = MS_CHAIN_E;
					default: cmd.mul_src = MS_CHAIN_M;
				endcase
				state_d = ST_RHS;
			end
			ST_RHS: begin
				if (!status.mul_busy) begin
					if (step_q == RHS_LAST) begin
						state_d = ST_FINISH;
					end else begin
						step_d  = step_q + 3'd1;
						state_d = ST_RHS_GO;
					end
				end
			end
			ST_FINISH: begin
				cmd.op  = DP_FINISH;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

`ifndef SYNTHESIS
	a_idle_units_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!status.div_busy && !status.mul_busy))
		else $error("arithmetic unit running while controller idle");
	a_start_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> (state_q == ST_READ))
		else $error("accepted item did not start a table read");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q <= RHS_LAST))
		else $error("right-hand product chain step out of range");
`endif

endmodule

// ===== hdl/rssd_datapath.sv =====
module rssd_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rssd_pkg::dp_cmd_t    cmd,
	output rssd_pkg::dp_status_t status,
	input  rssd_pkg::in_item_t   item,
	input  rssd_pkg::cfg_t       cfg,
	output rssd_pkg::out_item_t  result,
	output logic                 done
);
	import rssd_pkg::*;

	localparam logic [LIMB_IW-1:0] LAST_LIMB = LIMB_IW'(LIMBS - 1);
	localparam logic [DIV_CW-1:0]  LAST_BIT  = '1;

	// Entry table with one valid bit per row; a row never written reads as zero.
	row_t             mem_q [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	row_t             mem_rd_q;
	logic             valid_rd_q;

	in_item_t          item_q;
	row_t              row_q, nrow_q;
	logic [MEAN_W-1:0] x_q, ad_q, ar_q;
	logic              dneg_q;
	logic [31:0]       tp_q;
	logic [SQ_W-1:0]   var_q;
	logic [BIG_W-1:0]  lhs_q;
	out_item_t         result_q;
	logic              done_q;

	// Serial restoring divider.
	logic              div_run_q;
	logic [DIV_CW-1:0] div_cnt_q;
	logic [31:0]       div_rem_q, div_den_q;
	logic [DIV_W-1:0]  div_quo_q;
	logic [32:0]       rem_sh;
	logic              rem_ge;
	logic [DIV_W-1:0]  div_num;
	logic [31:0]       div_den;

	// Limb-serial multiplier: product = A * v, one 32x32 partial per cycle.
	logic [LIMB_W-1:0]  a_q [LIMBS];
	logic [LIMB_W-1:0]  r_q [LIMBS];
	logic [SQ_W-1:0]    mul_v_q;
	logic [LIMB_W-1:0]  carry_q;
	logic               mul_run_q;
	logic [LIMB_IW-1:0] mul_i_q;
	logic               mul_j_q;
	logic [LIMB_IW:0]   kx;
	logic [LIMB_W-1:0]  rk, vj;
	logic [2*LIMB_W-1:0] part;
	logic [BIG_W-1:0]   r_vec, a_src;
	logic [SQ_W-1:0]    v_src;

	logic              div_start, mul_start;
	logic [31:0]       t_one, u_one;
	logic [SQ_W-1:0]   sq_inc;
	logic [SQ_W:0]     sq_sum;

	assign div_start = (cmd.op == DP_DIV_START);
	assign mul_start = (cmd.op == DP_MUL_START);
	assign t_one = (item_q.exec_time_ns == '0) ? 32'd1 : item_q.exec_time_ns;
	assign u_one = (item_q.work_units == '0) ? 32'd1 : item_q.work_units;

	always_comb begin
		for (int l = 0; l < LIMBS; l++) begin
			r_vec[l*LIMB_W +: LIMB_W] = r_q[l];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == DP_WRITE) begin
			mem_q[item_q.entry] <= nrow_q;
		end
		mem_rd_q <= mem_q[item_q.entry];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			valid_rd_q <= 1'b0;
		end else begin
			if (cmd.op == DP_WRITE) begin
				valid_q[item_q.entry] <= 1'b1;
			end
			valid_rd_q <= valid_q[item_q.entry];
		end
	end

	always_comb begin
		case (cmd.div_src)
			DS_RATE: begin
				div_num = DIV_W'({u_one, {FRAC_BITS{1'b0}}});
				div_den = tp_q;
			end
			DS_DELTA: begin
				div_num = DIV_W'(ad_q);
				div_den = nrow_q.count;
			end
			DS_VAR: begin
				div_num = nrow_q.sqdev;
				div_den = nrow_q.count - 32'd1;
			end
			default: begin
				div_num = '0;
				div_den = 32'd1;
			end
		endcase
	end

	assign rem_sh = {div_rem_q, div_quo_q[DIV_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, div_den_q});

	always_ff @(posedge clk) begin
		if (div_start) begin
			div_den_q <= div_den;
			div_quo_q <= div_num;
			div_rem_q <= '0;
		end else if (div_run_q) begin
			div_rem_q <= rem_ge ? 32'(rem_sh - {1'b0, div_den_q}) : rem_sh[31:0];
			div_quo_q <= {div_quo_q[DIV_W-2:0], rem_ge};
		end
	end

	always_comb begin
		case (cmd.mul_src)
			MS_SQDEV: begin
				a_src = BIG_W'(ad_q);
				v_src = SQ_W'(ar_q);
			end
			MS_LHS: begin
				a_src = BIG_W'(var_q);
				v_src = SQ_W'(INTERVAL_Z2);
			end
			MS_RHS_N: begin
				a_src = BIG_W'(RHS_SCALE);
				v_src = SQ_W'(nrow_q.count);
			end
			MS_CHAIN_E: begin
				a_src = r_vec;
				v_src = SQ_W'(cfg.error_limit_q16);
			end
			MS_CHAIN_M: begin
				a_src = r_vec;
				v_src = SQ_W'(nrow_q.mean);
			end
			default: begin
				a_src = '0;
				v_src = '0;
			end
		endcase
	end

	assign kx   = {1'b0, mul_i_q} + {{LIMB_IW{1'b0}}, mul_j_q};
	assign rk   = (kx < (LIMB_IW + 1)'(LIMBS)) ? r_q[kx[LIMB_IW-1:0]] : '0;
	assign vj   = mul_j_q ? mul_v_q[SQ_W-1:LIMB_W] : mul_v_q[LIMB_W-1:0];
	assign part = a_q[mul_i_q] * vj + {{LIMB_W{1'b0}}, rk} + {{LIMB_W{1'b0}}, carry_q};

	always_ff @(posedge clk) begin
		if (mul_start) begin
			for (int l = 0; l < LIMBS; l++) begin
				a_q[l] <= a_src[l*LIMB_W +: LIMB_W];
				r_q[l] <= '0;
			end
			mul_v_q <= v_src;
			carry_q <= '0;
		end else if (mul_run_q) begin
			if (kx < (LIMB_IW + 1)'(LIMBS)) begin
				r_q[kx[LIMB_IW-1:0]] <= part[LIMB_W-1:0];
			end
			carry_q <= (mul_i_q == LAST_LIMB) ? '0 : part[2*LIMB_W-1:LIMB_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_run_q <= 1'b0;
			div_cnt_q <= '0;
			mul_run_q <= 1'b0;
			mul_i_q   <= '0;
			mul_j_q   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= (cmd.op == DP_FINISH);
			if (div_start) begin
				div_run_q <= 1'b1;
				div_cnt_q <= '0;
			end else if (div_run_q) begin
				div_cnt_q <= div_cnt_q + DIV_CW'(1);
				if (div_cnt_q == LAST_BIT) begin
					div_run_q <= 1'b0;
				end
			end
			if (mul_start) begin
				mul_run_q <= 1'b1;
				mul_i_q   <= '0;
				mul_j_q   <= 1'b0;
			end else if (mul_run_q) begin
				if (mul_i_q == LAST_LIMB) begin
					mul_i_q <= '0;
					if (mul_j_q) begin
						mul_run_q <= 1'b0;
					end else begin
						mul_j_q <= 1'b1;
					end
				end else begin
					mul_i_q <= mul_i_q + LIMB_IW'(1);
				end
			end
		end
	end

	// Increment of the squared-deviation sum: product shifted down, saturating.
	assign sq_inc = (|r_vec[BIG_W-1:SQ_W+FRAC_BITS]) ? '1 : r_vec[SQ_W+FRAC_BITS-1:FRAC_BITS];
	assign sq_sum = {1'b0, nrow_q.sqdev} + {1'b0, sq_inc};

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_CAPTURE: item_q <= item;
			DP_LATCH_ROW: begin
				row_q  <= valid_rd_q ? mem_rd_q : '0;
				nrow_q <= valid_rd_q ? mem_rd_q : '0;
			end
			DP_FOLD_PREP: begin
				tp_q            <= t_one;
				x_q             <= {t_one, {FRAC_BITS{1'b0}}};
				nrow_q.count    <= (row_q.count != '1) ? row_q.count + 32'd1 : row_q.count;
				nrow_q.unit_sum <= sat_add48(row_q.unit_sum, item_q.work_units);
				nrow_q.time_sum <= sat_add48(row_q.time_sum, t_one);
			end
			DP_OTHER_UPD: begin
				if (cfg.update_enable) begin
					case (item_q.mode)
						MODE_SAMPLE: begin
							if (row_q.skip_count != '1) begin
								nrow_q.skip_count <= row_q.skip_count + 32'd1;
							end
							nrow_q.skip_unit_sum <= sat_add48(row_q.skip_unit_sum,
								item_q.work_units);
						end
						MODE_LOCAL:  nrow_q.local_mark  <= !item_q.keep_sched;
						MODE_GLOBAL: nrow_q.global_mark <= !item_q.keep_sched;
						default: ;
					endcase
				end
			end
			DP_X_TAKE: begin
				x_q <= (|div_quo_q[DIV_W-1:MEAN_W]) ? '1 : div_quo_q[MEAN_W-1:0];
			end
			DP_DELTA: begin
				dneg_q <= (x_q < row_q.mean);
				ad_q   <= (x_q < row_q.mean) ? row_q.mean - x_q : x_q - row_q.mean;
			end
			DP_MEAN_UPD: begin
				nrow_q.mean <= dneg_q ? row_q.mean - div_quo_q[MEAN_W-1:0]
					: row_q.mean + div_quo_q[MEAN_W-1:0];
			end
			DP_RESID: begin
				ar_q <= (x_q >= nrow_q.mean) ? x_q - nrow_q.mean : nrow_q.mean - x_q;
			end
			DP_SQ_UPD: nrow_q.sqdev <= sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
			DP_VAR_CONST: var_q <= VAR_EMPTY;
			DP_VAR_TAKE: var_q <= div_quo_q;
			DP_LHS_TAKE: lhs_q <= r_vec << LHS_SHIFT;
			DP_FINISH: begin
				result_q.mean_value      <= nrow_q.mean;
				result_q.variance_value  <= var_q;
				result_q.steady_met      <= !item_q.barrier_key && (lhs_q < r_vec)
					&& (nrow_q.count >= cfg.count_limit)
					&& (nrow_q.time_sum >= cfg.time_limit_ns);
				result_q.schedule_local  <= !nrow_q.local_mark;
				result_q.schedule_global <= !nrow_q.global_mark;
				result_q.sample_count    <= nrow_q.count;
			end
			default: ;
		endcase
	end

	assign status.fold      = cfg.update_enable && (item_q.mode == MODE_SAMPLE)
		&& !row_q.local_mark;
	assign status.rate      = cfg.rate_mode;
	assign status.var_const = (nrow_q.count <= 32'd1);
	assign status.div_busy  = div_run_q;
	assign status.mul_busy  = mul_run_q;

	assign result = result_q;
	assign done   = done_q;

endmodule

// ===== hdl/running_stats_steady_detector_core.sv =====
// Running statistics table with a steadiness detector. Each item addresses one of
// 256 entries and answers with exactly one result item, shown on result for a single
// cycle while done is high; the receiver cannot hold it off, so it must take the
// result in that cycle. A new item is accepted when start is high and busy is low,
// and busy stays high until the result is issued. Busy is low in the cycle in which
// done is high, so the next item can be taken at its end. When the entry holds at
// most one sample the variance is the fixed value and the variance division is
// skipped. The time an item takes is set by the shared 64-step serial divider,
// used for the rate quotient, the mean step and the variance, and by the
// limb-serial 32x32 multiplier, which forms each product from 14 partial products,
// for the squared-deviation term and for each of the six products of the interval
// test. Configuration is written through cfg_valid/cfg_ready, which is always
// ready, and must only be written while the block is idle.
module running_stats_steady_detector_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rssd_pkg::in_item_t  item,
	output logic                done,
	output rssd_pkg::out_item_t result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data
);
	import rssd_pkg::*;

	cfg_t       cfg_q;
	dp_cmd_t    cmd;
	dp_status_t status;

	// Configuration registers; writes to indexes past the last register are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate_mode       <= 1'b0;
			cfg_q.update_enable   <= 1'b1;
			cfg_q.count_limit     <= 32'd1;
			cfg_q.time_limit_ns   <= 48'd10000;
			cfg_q.error_limit_q16 <= 32'd32768;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_RATE_MODE:   cfg_q.rate_mode       <= cfg_data[0];
				CFG_UPDATE_EN:   cfg_q.update_enable   <= cfg_data[0];
				CFG_COUNT_LIMIT: cfg_q.count_limit     <= cfg_data[31:0];
				CFG_TIME_LIMIT:  cfg_q.time_limit_ns   <= cfg_data[47:0];
				CFG_ERROR_LIMIT: cfg_q.error_limit_q16 <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// The controller sequences the table access and the arithmetic units.
	rssd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	// The datapath holds the table, the divider, the multiplier and the result register.
	rssd_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.status (status),
		.item   (item),
		.cfg    (cfg_q),
		.result (result),
		.done   (done)
	);

endmodule

// ===== tb/running_stats_steady_detector_core_checker.sv =====
module running_stats_steady_detector_core_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  rssd_pkg::in_item_t  item,
	input  logic                done,
	input  rssd_pkg::out_item_t result,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	output int                  fail_count,
	output int                  pending_count,
	output int                  result_count,
	output int                  steady_count
);
	import rssd_pkg::*;

	localparam logic [63:0] M48 = 64'hFFFF_FFFF_FFFF;

	logic        p_rate, p_upd;
	logic [31:0] p_cnt_lim, p_err;
	logic [47:0] p_time_lim;

	logic        lmark [ENTRIES];
	logic        gmark [ENTRIES];
	logic [31:0] n_tab [ENTRIES];
	logic [31:0] skip_tab [ENTRIES];
	logic [47:0] usum_tab [ENTRIES];
	logic [47:0] skip_usum_tab [ENTRIES];
	logic [47:0] tsum_tab [ENTRIES];
	logic [47:0] mean_tab [ENTRIES];
	logic [63:0] sq_tab [ENTRIES];

	out_item_t expected_results[$];

	function automatic logic [47:0] add_sat48(logic [47:0] a, logic [31:0] b);
		logic [48:0] s;
		s = {1'b0, a} + 49'(b);
		return s[48] ? M48[47:0] : s[47:0];
	endfunction

	function automatic void fold_into_entry(int e, logic [31:0] t_in, logic [31:0] u);
		logic [63:0] t, x, m, mnew, ad, ar, inc, s;
		logic [127:0] prod;
		logic signed [63:0] d, dn, r;
		logic [31:0] c;
		t = (t_in == 0) ? 64'd1 : 64'(t_in);
		c = n_tab[e];
		if (c != 32'hFFFF_FFFF) c = c + 1;
		n_tab[e] = c;
		usum_tab[e] = add_sat48(usum_tab[e], u);
		tsum_tab[e] = add_sat48(tsum_tab[e], t[31:0]);
		if (p_rate) x = ((u == 0 ? 64'd1 : 64'(u)) << FRAC_BITS) / t;
		else x = t << FRAC_BITS;
		if (x > M48) x = M48;
		m = 64'(mean_tab[e]);
		d = $signed(x) - $signed(m);
		dn = d / $signed(64'(c));
		mnew = m + dn;
		r = $signed(x) - $signed(mnew);
		ad = d < 0 ? -d : d;
		ar = r < 0 ? -r : r;
		mean_tab[e] = mnew[47:0];
		prod = 128'(ad) * 128'(ar);
		if (prod[127:64+FRAC_BITS] != 0) inc = '1;
		else inc = prod[63+FRAC_BITS:FRAC_BITS];
		s = sq_tab[e] + inc;
		sq_tab[e] = (s < inc) ? '1 : s;
	endfunction

	function automatic out_item_t predict_item(in_item_t it);
		out_item_t o;
		int e;
		logic [63:0] v, n;
		logic [255:0] lhs, rhs;
		e = int'(it.entry) % ENTRIES;
		if (p_upd) begin
			case (it.mode)
				MODE_SAMPLE: begin
					if (!lmark[e]) fold_into_entry(e, it.exec_time_ns, it.work_units);
					else begin
						if (skip_tab[e] != 32'hFFFF_FFFF) skip_tab[e]++;
						skip_usum_tab[e] = add_sat48(skip_usum_tab[e], it.work_units);
					end
				end
				MODE_LOCAL: lmark[e] = !it.keep_sched;
				MODE_GLOBAL: gmark[e] = !it.keep_sched;
				default: ;
			endcase
		end
		n = 64'(n_tab[e]);
		v = (n <= 1) ? VAR_EMPTY : sq_tab[e] / (n - 1);
		lhs = 256'(v) * 256'(INTERVAL_Z2) * (256'(1) << LHS_SHIFT);
		rhs = 256'(RHS_SCALE) * 256'(n) * 256'(p_err) * 256'(p_err)
			* 256'(mean_tab[e]) * 256'(mean_tab[e]);
		o.mean_value = mean_tab[e];
		o.variance_value = v;
		o.steady_met = !it.barrier_key && n != 0 && lhs < rhs && n >= 64'(p_cnt_lim)
			&& tsum_tab[e] >= p_time_lim;
		o.schedule_local = !lmark[e];
		o.schedule_global = !gmark[e];
		o.sample_count = n_tab[e];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t ex;
		if (!arst_n) begin
			p_rate = 0; p_upd = 1; p_cnt_lim = 1; p_time_lim = 10000; p_err = 32768;
			for (int i = 0; i < ENTRIES; i++) begin
				lmark[i] = 0; gmark[i] = 0; n_tab[i] = 0; skip_tab[i] = 0;
				usum_tab[i] = 0; skip_usum_tab[i] = 0; tsum_tab[i] = 0;
				mean_tab[i] = 0; sq_tab[i] = 0;
			end
			expected_results.delete();
			fail_count = 0; result_count = 0; steady_count = 0;
		end else begin
			if (done) begin
				result_count++;
				if (result.steady_met) steady_count++;
				if (expected_results.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result %p", $time, result);
				end else begin
					ex = expected_results.pop_front();
					if (result !== ex) begin
						fail_count++;
						$display("%0t: result mismatch expected %p actual %p",
							$time, ex, result);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RATE_MODE:   p_rate = cfg_data[0];
					CFG_UPDATE_EN:   p_upd = cfg_data[0];
					CFG_COUNT_LIMIT: p_cnt_lim = cfg_data[31:0];
					CFG_TIME_LIMIT:  p_time_lim = cfg_data[47:0];
					CFG_ERROR_LIMIT: p_err = cfg_data[31:0];
					default: ;
				endcase
			end
			if (start && !busy) expected_results.push_back(predict_item(item));
		end
		pending_count = expected_results.size();
	end
endmodule

// ===== tb/running_stats_steady_detector_core_tb.sv =====
module running_stats_steady_detector_core_tb;
	import rssd_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	in_item_t    item = '0;
	logic        done;
	out_item_t   result;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_RATE_MODE;
	logic [63:0] cfg_data = '0;
	int          fail_count, pending_count, result_count, steady_count;
	int          items_sent = 0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	running_stats_steady_detector_core u_dut (
		.clk, .arst_n, .start, .busy, .item, .done, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	running_stats_steady_detector_core_checker u_chk (
		.clk, .arst_n, .start, .busy, .item, .done, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.fail_count, .pending_count, .result_count, .steady_count
	);

	// Hands one item to the block: wait a random gap, raise start on a falling
	// edge and hold it until a rising edge sees busy low. Start is lowered on the
	// next falling edge.
	task automatic send_item(in_item_t it, bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 15) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0;
		repeat (gap) @(negedge clk);
		item = it;
		start = 1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		start = 0;
		items_sent++;
	endtask

	// Registers are written only with the block idle: every expected result has
	// arrived and busy is low.
	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		wait (pending_count == 0 && !busy);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 0;
	endtask

	function automatic in_item_t make_item(logic [1:0] m, logic [7:0] e, logic [31:0] t,
			logic [31:0] u, logic k, logic b);
		in_item_t it;
		it.mode = m; it.entry = e; it.exec_time_ns = t; it.work_units = u;
		it.keep_sched = k; it.barrier_key = b;
		return it;
	endfunction

	// Random item. Most are samples on a handful of hot entries with times
	// clustered near a base so that entries can actually become steady; the
	// rest are mark writes, wide random values, mode 3 and barrier samples.
	function automatic in_item_t rand_item();
		in_item_t it;
		int r;
		r = $urandom_range(0, 99);
		it.entry = (r < 80) ? 8'($urandom_range(0, 7)) : 8'($urandom);
		it.keep_sched = $urandom_range(0, 4) != 0;
		it.barrier_key = $urandom_range(0, 9) == 0;
		it.work_units = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100);
		if (r < 70) begin
			it.mode = MODE_SAMPLE;
			it.exec_time_ns = 32'(2000 + $urandom_range(0, 200));
		end else if (r < 80) begin
			it.mode = MODE_SAMPLE;
			it.exec_time_ns = $urandom;
		end else if (r < 90) begin
			it.mode = MODE_LOCAL;
			it.exec_time_ns = $urandom;
		end else if (r < 97) begin
			it.mode = MODE_GLOBAL;
			it.exec_time_ns = $urandom;
		end else begin
			it.mode = 2'd3;
			it.exec_time_ns = $urandom;
		end
		return it;
	endfunction

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: empty entry, extreme times and units, zero time read as one,
		// every mark write, mode 3, barrier and the last entry.
		send_item(make_item(MODE_SAMPLE, 8'd255, 32'd0, 32'd0, 1'b0, 1'b0), 0);
		send_item(make_item(2'd3, 8'd10, '1, '1, 1'b1, 1'b1), 0);
		send_item(make_item(MODE_SAMPLE, 8'd10, '1, '1, 1'b1, 1'b0), 0);
		send_item(make_item(MODE_SAMPLE, 8'd10, 32'd0, '1, 1'b0, 1'b0), 0);
		send_item(make_item(MODE_SAMPLE, 8'd10, 32'd1, 32'd0, 1'b0, 1'b1), 0);
		send_item(make_item(MODE_LOCAL, 8'd10, '1, '1, 1'b0, 1'b0), 0);
		send_item(make_item(MODE_SAMPLE, 8'd10, 32'd5, 32'd7, 1'b0, 1'b0), 0);
		send_item(make_item(MODE_LOCAL, 8'd10, 32'd0, 32'd0, 1'b1, 1'b0), 0);
		send_item(make_item(MODE_GLOBAL, 8'd10, 32'd0, 32'd0, 1'b0, 1'b0), 0);
		send_item(make_item(MODE_GLOBAL, 8'd10, 32'd0, 32'd0, 1'b1, 1'b0), 0);
		for (int i = 0; i < 6; i++)
			send_item(make_item(MODE_SAMPLE, 8'd1, 32'd5000, 32'd3, 1'b0, 1'b0), 0);

		// Rate mode with extremes; the error limit at both ends.
		write_reg(CFG_RATE_MODE, 64'd1);
		write_reg(CFG_ERROR_LIMIT, 64'hFFFF_FFFF);
		send_item(make_item(MODE_SAMPLE, 8'd20, 32'd1, '1, 1'b0, 1'b0), 0);
		send_item(make_item(MODE_SAMPLE, 8'd20, '1, 32'd0, 1'b0, 1'b0), 0);
		send_item(make_item(MODE_SAMPLE, 8'd20, 32'd0, 32'd1, 1'b0, 1'b0), 0);
		write_reg(CFG_ERROR_LIMIT, 64'd0);
		send_item(make_item(MODE_SAMPLE, 8'd1, 32'd5000, 32'd3, 1'b0, 1'b0), 0);

		// Updates off: state stays put, results still come.
		write_reg(CFG_UPDATE_EN, 64'd0);
		send_item(make_item(MODE_SAMPLE, 8'd1, 32'd9, 32'd9, 1'b0, 1'b0), 0);
		send_item(make_item(MODE_LOCAL, 8'd1, 32'd9, 32'd9, 1'b0, 1'b0), 0);
		write_reg(CFG_UPDATE_EN, 64'd1);

		// Random phases, each under a different register setting.
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(CFG_RATE_MODE, 64'(ph % 2));
			write_reg(CFG_COUNT_LIMIT, ph == 5 ? 64'hFFFF_FFFF : 64'($urandom_range(0, 8)));
			write_reg(CFG_TIME_LIMIT, ph == 4 ? 64'hFFFF_FFFF_FFFF :
				ph == 3 ? 64'd0 : 64'($urandom_range(0, 20000)));
			write_reg(CFG_ERROR_LIMIT, ph == 2 ? 64'hFFFF_FFFF :
				64'($urandom_range(1000, 70000)));
			write_reg(CFG_UPDATE_EN, 64'(ph != 1 || $urandom_range(0, 1)));
			for (int i = 0; i < 80; i++) send_item(rand_item(), i >= 20);
		end
		write_reg(CFG_UPDATE_EN, 64'd1);

		wait (pending_count == 0);
		repeat (400) @(posedge clk);
		$display("Sent %0d items, checked %0d results, %0d of them steady.",
			items_sent, result_count, steady_count);
		$display("Covered time and rate modes, mark writes, updates off and register extremes.");
		if (fail_count == 0) begin
			$display("running_stats_steady_detector_core_tb: done, clean");
		end else begin
			$display("running_stats_steady_detector_core_tb: done, errors");
		end
		$finish;
	end

	// Slowest run: 502 items with their random gaps.
	initial begin
		#(12 * 1000000);
		$display("running_stats_steady_detector_core_tb: done, errors");
		$finish;
	end
endmodule
